// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the base32 stream encoder.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Check a property in the cycle after a condition, outside reset.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/core/b32e_pkg.sv =====
// Package for the base32 byte stream encoder: slice record and alphabet lookup.
// No dependencies; used by b32e_slicer, b32e_char_queue and the top level.
`timescale 1ns / 1ps
`default_nettype none

package b32e_pkg;

  localparam int unsigned GroupBits = 5;
  localparam int unsigned CharBits  = 7;
  localparam int unsigned HeldBits  = 4;
  localparam int unsigned MaxGroups = 3;

  // Up to three 5-bit groups cut from one byte, with their count (1..3).
  typedef struct packed {
    logic [MaxGroups-1:0][GroupBits-1:0] groups;
    logic [1:0]                          count;
    logic                                msg_end;
  } slice_t;

  localparam logic [CharBits-1:0] ALPHABET [32] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46,
    7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4D, 7'h4E, 7'h50, 7'h51,
    7'h52, 7'h53, 7'h54, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A
  };

  function automatic logic [CharBits-1:0] b32e_char(input logic [GroupBits-1:0] group);
    return ALPHABET[group];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/b32e_slicer.sv =====
// Combinational group cutter: joins held bits with a new byte, cuts 5-bit groups.
// Depends on b32e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b32e_slicer import b32e_pkg::*; (
  input  logic [HeldBits-1:0] held_bits,
  input  logic [2:0]          held_count,
  input  logic [7:0]          data_byte,
  input  logic                msg_end,
  output slice_t              slice,
  output logic [HeldBits-1:0] next_bits,
  output logic [2:0]          next_count
);

  logic [2:0]          cnt;
  logic [2:0]          rem;
  logic [HeldBits-1:0] held_mask;
  logic [11:0]         acc;
  logic [11:0]         win;
  logic                two_full;

  always_comb begin
    cnt       = (held_count > 3'd4) ? 3'd4 : held_count;
    held_mask = 4'hf >> (3'd4 - cnt);
    acc       = {held_bits & held_mask, data_byte};
    // MSB-align the valid bits so groups sit at fixed positions
    win       = acc << (3'd4 - cnt);
    two_full  = (cnt >= 3'd2);
    rem       = two_full ? (cnt - 3'd2) : (cnt + 3'd3);

    slice.groups[0] = win[11:7];
    slice.groups[1] = win[6:2];
    slice.groups[2] = {win[1:0], 3'b000};
    slice.msg_end   = msg_end;
    if (two_full) begin
      slice.count = (msg_end && (rem != 3'd0)) ? 2'd3 : 2'd2;
    end else begin
      slice.count = msg_end ? 2'd2 : 2'd1;
    end

    if (msg_end) begin
      next_bits  = '0;
      next_count = 3'd0;
    end else begin
      next_bits  = acc[HeldBits-1:0] & (4'hf >> (3'd4 - rem));
      next_count = rem;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b32e_char_queue.sv =====
// Slice buffer and output register: emits a slice's groups, one per cycle while out_ready is high.
// Depends on b32e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b32e_char_queue import b32e_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  slice_t              slice,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CharBits-1:0] out_char,
  output logic                out_run_last,
  output logic                out_msg_last
);

  logic   buf_valid;
  slice_t buf_slice;
  logic [1:0] idx;
  logic   out_load;
  logic   buf_last;
  logic   drain;
  logic   accept;

  assign out_load = !out_valid || out_ready;
  assign buf_last = (idx == (buf_slice.count - 2'd1));
  assign drain    = buf_valid && out_load;
  assign in_ready = !buf_valid || (drain && buf_last);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        buf_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (drain && buf_last) begin
        buf_valid <= 1'b0;
      end else if (drain) begin
        idx <= idx + 2'd1;
      end
      if (out_load) begin
        out_valid <= buf_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_slice <= slice;
    end
    if (drain) begin
      out_char     <= b32e_char(buf_slice.groups[idx]);
      out_run_last <= buf_last;
      out_msg_last <= buf_last && buf_slice.msg_end;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/base32_byte_stream_encoder.sv =====
// Top level of the base32 byte stream encoder (Crockford alphabet, no padding).
// Depends on b32e_pkg, b32e_slicer, b32e_char_queue and assert_macros.svh.
//
// Usage:
//   Input stream: one message byte per transaction on s_tdata, s_tlast high
//   on the last byte of a message. Output stream: one ASCII character per
//   transaction on m_tdata, m_tuser high on the last character produced by
//   one input byte, m_tlast high on the last character of the message.
//   Path: a byte is held in the slice buffer, then each of its characters
//   passes through the output register. Throughput: a byte stays in the
//   slice buffer until its characters (1 to 3, 1.6 on average over a message)
//   have all moved on, at one per cycle while m_tready is high. The next byte
//   is taken in the same cycle the last character of the current one moves
//   to the output register, so bytes follow back to back.
//   Reset clears the held bits, the slice buffer and the output register.
//   When the receiver stalls, hold the output character, keep the buffered
//   slice, and drop s_tready once the buffer is full.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module base32_byte_stream_encoder import b32e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // message_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  output logic       m_tlast,   // message_last
  output logic       m_tuser    // [0] run_last
);

  // Bits of the stream not yet cut into a group
  logic [HeldBits-1:0] leftover_bits;
  logic [2:0]          leftover_count;
  logic [HeldBits-1:0] leftover_bits_next;
  logic [2:0]          leftover_count_next;

  slice_t              slice;
  logic [CharBits-1:0] out_char;
  logic                s_accept;

  assign s_accept = s_tvalid && s_tready;

  b32e_slicer u_slicer (
    .held_bits  (leftover_bits),
    .held_count (leftover_count),
    .data_byte  (s_tdata),
    .msg_end    (s_tlast),
    .slice      (slice),
    .next_bits  (leftover_bits_next),
    .next_count (leftover_count_next)
  );

  b32e_char_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .slice        (slice),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_char     (out_char),
    .out_run_last (m_tuser),
    .out_msg_last (m_tlast)
  );

  // Advance the held bits only on an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits  <= '0;
      leftover_count <= 3'd0;
    end else if (s_accept) begin
      leftover_bits  <= leftover_bits_next;
      leftover_count <= leftover_count_next;
    end
  end

  assign m_tdata = {1'b0, out_char};

  `ASSERT_IMPLY(a_held_count_range, 1'b1, leftover_count <= 3'd4,
                "held bit count above four")
  `ASSERT_NEXT(a_clear_on_end, s_accept && s_tlast, leftover_count == 3'd0,
               "held bits not cleared after message end")
  `ASSERT_IMPLY(a_msg_last_ends_run, m_tvalid && m_tlast, m_tuser,
                "message end not on the last character of its byte")
  `ASSERT_IMPLY(a_char_range, m_tvalid, (m_tdata[6:0] >= 7'h30) && (m_tdata[6:0] <= 7'h5A),
                "output character outside the alphabet range")

endmodule

`default_nettype wire
